/* src/magic_length_frame_decoder_macros.svh */
// ----------------------------------------------------------------------------
// magic_length_frame_decoder_macros.svh
// Assertion helpers used by the mlfd_core module.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_FRAME_DECODER_MACROS_SVH
`define MAGIC_LENGTH_FRAME_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mlfd_pkg.sv */
// ----------------------------------------------------------------------------
// mlfd_pkg
// Types, constants and helpers for the magic/length frame decoder.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam logic [31:0] DEFAULT_MAX_FRAME = 32'd1048576;
  localparam logic [31:0] HEADER_BYTES      = 32'd8;

  localparam logic [7:0] MAGIC_HI = 8'haa;
  localparam logic [7:0] MAGIC_LO = 8'h55;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_TOO_SHORT = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Index of the last header byte within a frame.
  localparam logic [2:0] HDR_LAST = 3'd7;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       body_valid;
    logic [7:0] body_out;
    logic       frame_end;
  } result_t;

  // Expected magic byte at a given header position (positions 0 to 3).
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = MAGIC_HI;
      2'd1:    val = MAGIC_HI;
      2'd2:    val = MAGIC_LO;
      2'd3:    val = MAGIC_LO;
      default: val = MAGIC_HI;
    endcase
    return val;
  endfunction

endpackage

/* src/magic_length_frame_decoder.sv */
// ----------------------------------------------------------------------------
// magic_length_frame_decoder
// Cut-through decoder for byte streams framed by a magic word and a length.
// ----------------------------------------------------------------------------
// The decoder takes one byte or clear operation per clock, unless in_stall is
// high, and returns exactly one result per item. Each item passes through the
// input register and then the result register, with the header check and
// byte count done in a single pass between them. The output register frees
// itself in the cycle its result is taken, so with no stall on the output
// the sustained rate is one item every clock.
module magic_length_frame_decoder
  import mlfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        body_valid,
  output logic [7:0]  body_out,
  output logic        frame_end
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  result_t core_result;
  result_t out_result;

  assign in_item.op        = op;
  assign in_item.data_byte = data_byte;

  mlfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mlfd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (held_valid && take),
    .item        (held_item),
    .result      (core_result)
  );

  mlfd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (held_valid),
    .load_result (core_result),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  assign status     = out_result.status;
  assign body_valid = out_result.body_valid;
  assign body_out   = out_result.body_out;
  assign frame_end  = out_result.frame_end;

endmodule

/* src/mlfd_in_reg.sv */
// ----------------------------------------------------------------------------
// mlfd_in_reg
// Input register: captures one item per transfer and holds it until the
// decode stage takes it.
// ----------------------------------------------------------------------------
module mlfd_in_reg
  import mlfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  logic  valid;
  item_t item;

  // The held item leaves when the decode stage takes it, so a new one may
  // enter in the same cycle.
  assign in_stall = valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  assign held_valid = valid;
  assign held_item  = item;

endmodule

/* src/mlfd_core.sv */
// ----------------------------------------------------------------------------
// mlfd_core
// Frame state and single-pass decode of one stream byte, plus the maximum
// frame size register.
// ----------------------------------------------------------------------------
`include "magic_length_frame_decoder_macros.svh"

module mlfd_core
  import mlfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        advance,
  input  item_t       item,
  output result_t     result
);

  logic [31:0] max_frame_size;
  logic [2:0]  header_count;
  logic        magic_ok;
  logic [31:0] length_accum;
  logic [31:0] body_remaining;
  logic [1:0]  sticky_error;

  logic [2:0]  header_count_next;
  logic        magic_ok_next;
  logic [31:0] length_accum_next;
  logic [31:0] body_remaining_next;
  logic [1:0]  sticky_error_next;

  logic        byte_match;
  logic        magic_ok_upd;
  logic [31:0] accum_upd;
  logic [31:0] limit;
  logic [1:0]  hdr_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_size <= '0;
    end else if (cfg_wr_en) begin
      max_frame_size <= cfg_wr_data;
    end
  end

  always_comb begin
    byte_match   = (item.data_byte == magic_byte(header_count[1:0]));
    magic_ok_upd = magic_ok && (header_count[2] || byte_match);
    // Length bytes follow the four magic bytes, most significant first.
    accum_upd    = header_count[2] ? {length_accum[23:0], item.data_byte} : length_accum;
    limit        = (max_frame_size == '0) ? DEFAULT_MAX_FRAME : max_frame_size;

    if (!magic_ok_upd) begin
      hdr_err = ST_BAD_MAGIC;
    end else if (accum_upd < HEADER_BYTES) begin
      hdr_err = ST_TOO_SHORT;
    end else if (accum_upd > limit) begin
      hdr_err = ST_TOO_LARGE;
    end else begin
      hdr_err = ST_OK;
    end
  end

  always_comb begin
    header_count_next   = header_count;
    magic_ok_next       = magic_ok;
    length_accum_next   = length_accum;
    body_remaining_next = body_remaining;
    sticky_error_next   = sticky_error;
    result              = '0;

    if (item.op == OP_CLEAR) begin
      header_count_next   = '0;
      magic_ok_next       = 1'b1;
      length_accum_next   = '0;
      body_remaining_next = '0;
      sticky_error_next   = ST_OK;
    end else if (sticky_error != ST_OK) begin
      result.status = sticky_error;
    end else if (body_remaining != '0) begin
      body_remaining_next = body_remaining - 32'd1;
      result.body_valid   = 1'b1;
      result.body_out     = item.data_byte;
      result.frame_end    = (body_remaining == 32'd1);
    end else if (header_count != HDR_LAST) begin
      header_count_next = header_count + 3'd1;
      magic_ok_next     = magic_ok_upd;
      length_accum_next = accum_upd;
    end else begin
      header_count_next = '0;
      magic_ok_next     = 1'b1;
      length_accum_next = '0;
      if (hdr_err != ST_OK) begin
        sticky_error_next = hdr_err;
        result.status     = hdr_err;
      end else begin
        body_remaining_next = accum_upd - HEADER_BYTES;
        result.frame_end    = (accum_upd == HEADER_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count   <= '0;
      magic_ok       <= 1'b1;
      length_accum   <= '0;
      body_remaining <= '0;
      sticky_error   <= ST_OK;
    end else if (advance) begin
      header_count   <= header_count_next;
      magic_ok       <= magic_ok_next;
      length_accum   <= length_accum_next;
      body_remaining <= body_remaining_next;
      sticky_error   <= sticky_error_next;
    end
  end

  `MLFD_ASSERT_SAME(a_err_idle, (sticky_error != ST_OK), ((body_remaining == '0) && (header_count == '0)), "error latched while a frame is in progress")
  `MLFD_ASSERT_SAME(a_body_no_hdr, (body_remaining != '0), (header_count == '0), "header and body counted at once")
  `MLFD_ASSERT_SAME(a_body_ok, result.body_valid, (result.status == ST_OK), "body byte carries an error status")
  `MLFD_ASSERT_NEXT(a_clear, (advance && (item.op == OP_CLEAR)), ((sticky_error == ST_OK) && (body_remaining == '0) && (header_count == '0)), "clear left state behind")

endmodule

/* src/mlfd_out_reg.sv */
// ----------------------------------------------------------------------------
// mlfd_out_reg
// Result register: holds one decoded result until the output transfer, and
// accepts the next one in the cycle the current one leaves.
// ----------------------------------------------------------------------------
module mlfd_out_reg
  import mlfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  input  result_t load_result,
  output logic    take,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  logic    valid;
  result_t held;

  assign take = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      held <= load_result;
    end
  end

  assign out_valid  = valid;
  assign out_result = held;

endmodule
